>>> rtl/mrpt_pkg.sv
package mrpt_pkg;

   localparam int NUM_WIDTH      = 64;
   localparam int NUM_BASES      = 12;
   localparam int BASE_TABLE_LEN = 12;
   localparam int BASES_USED     = (NUM_BASES < BASE_TABLE_LEN) ? NUM_BASES : BASE_TABLE_LEN;
   localparam int IDX_W          = $clog2(BASES_USED + 1);
   localparam int CNT_W          = $clog2(NUM_WIDTH);
   localparam int BASE_W         = 8;

   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   // request to the modular multiplier: product = a * b mod n, a and b below n
   typedef struct packed {
      logic    start;
      num_type a;
      num_type b;
      num_type n;
   } mm_req_type;

   typedef struct packed {
      logic    done;
      num_type product;
   } mm_rsp_type;

   function automatic logic [BASE_W-1:0] base_value(input idx_type idx);
      logic [BASE_W-1:0] v;
      unique case (idx)
         IDX_W'(0):  v = 8'd2;
         IDX_W'(1):  v = 8'd3;
         IDX_W'(2):  v = 8'd5;
         IDX_W'(3):  v = 8'd7;
         IDX_W'(4):  v = 8'd11;
         IDX_W'(5):  v = 8'd13;
         IDX_W'(6):  v = 8'd17;
         IDX_W'(7):  v = 8'd19;
         IDX_W'(8):  v = 8'd23;
         IDX_W'(9):  v = 8'd29;
         IDX_W'(10): v = 8'd31;
         IDX_W'(11): v = 8'd37;
         default:    v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/mrpt_mulmod.sv
// Bit-serial interleaved modular multiplier, MSB of b first.
// Each bit runs in two steps: double, then conditional add, one add_mod each.
module mrpt_mulmod import mrpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type req,
   output mm_rsp_type rsp
);

   logic    busy_ff, busy_in;
   logic    phase_ff, phase_in;
   logic    done_ff, done_in;
   cnt_type cnt_ff, cnt_in;
   num_type acc_ff, acc_in;
   num_type a_ff, a_in;
   num_type b_ff, b_in;
   num_type n_ff, n_in;

   logic [NUM_WIDTH:0] sum;
   logic [NUM_WIDTH:0] diff;
   num_type            reduced;
   num_type            addend;

   assign addend  = phase_ff ? a_ff : acc_ff;
   assign sum     = {1'b0, acc_ff} + {1'b0, addend};
   assign diff    = sum - {1'b0, n_ff};
   assign reduced = (sum >= {1'b0, n_ff}) ? diff[NUM_WIDTH-1:0] : sum[NUM_WIDTH-1:0];

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      n_in     = n_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         acc_in   = '0;
         a_in     = req.a;
         b_in     = req.b;
         n_in     = req.n;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in   = reduced;
            phase_in = 1'b1;
         end else begin
            if (b_ff[NUM_WIDTH-1]) begin
               acc_in = reduced;
            end
            b_in     = {b_ff[NUM_WIDTH-2:0], 1'b0};
            phase_in = 1'b0;
            if (cnt_ff == CNT_W'(NUM_WIDTH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      n_ff     <= n_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

>>> rtl/miller_rabin_prime_test.sv
// Work: each base costs (bitlength(d) + popcount(d) - 1) modular multiplications plus
//   up to s-1 squarings, each run bit-serially in mrpt_mulmod; even candidates and one
//   are reported without any multiplication.
// Throughput: one candidate at a time, set by the single bit-serial multiplier.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
module miller_rabin_prime_test import mrpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] candidate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_prime, [7:1] zero
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,  // wait for a candidate
      ST_TZ      = 10'b0000000010,  // strip trailing zeros of n-1, one per cycle
      ST_BASE    = 10'b0000000100,  // pick next base or finish as prime
      ST_POW_CHK = 10'b0000001000,  // scan exponent bit, LSB first
      ST_POW_MUL = 10'b0000010000,  // x = x * p
      ST_POW_SQR = 10'b0000100000,  // p = p * p
      ST_CHECK   = 10'b0001000000,  // test x == 1 or x == n-1
      ST_LOOP    = 10'b0010000000,  // more squarings left?
      ST_SQ      = 10'b0100000000,  // x = x * x
      ST_REPORT  = 10'b1000000000   // hand result to output register
   } state_type;

   state_type state_ff, state_in;

   num_type n_ff, n_in;        // candidate, masked to the working width
   num_type m1_ff, m1_in;      // n - 1
   num_type d_ff, d_in;        // odd part of n - 1
   num_type e_ff, e_in;        // exponent shift register
   num_type x_ff, x_in;        // running power / witness value
   num_type p_ff, p_in;        // base raised to 2^k
   cnt_type s_ff, s_in;        // trailing zero count of n - 1
   cnt_type k_ff, k_in;        // squaring counter
   idx_type idx_ff, idx_in;    // base index
   logic    result_ff, result_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_data_ff, rsp_data_in;

   mm_req_type mm_req;
   mm_rsp_type mm_rsp;

   num_type cand;
   num_type base_now;

   assign cand     = req_tdata[NUM_WIDTH-1:0];
   assign base_now = NUM_WIDTH'(base_value(idx_ff));

   mrpt_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      m1_in        = m1_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mm_req.start = 1'b0;
      mm_req.a     = x_ff;
      mm_req.b     = p_ff;
      mm_req.n     = n_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in  = cand;
               m1_in = cand - NUM_WIDTH'(1);
               d_in  = cand - NUM_WIDTH'(1);
               s_in  = '0;
               if (!cand[0]) begin
                  // even: prime only for two
                  result_in = (cand == NUM_WIDTH'(2));
                  state_in  = ST_REPORT;
               end else if (cand == NUM_WIDTH'(1)) begin
                  result_in = 1'b0;
                  state_in  = ST_REPORT;
               end else begin
                  state_in = ST_TZ;
               end
            end
         end
         ST_TZ: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[NUM_WIDTH-1:1]};
               s_in = s_ff + CNT_W'(1);
            end else begin
               idx_in   = '0;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (idx_ff == IDX_W'(BASES_USED) || base_now >= n_ff) begin
               result_in = 1'b1;
               state_in  = ST_REPORT;
            end else begin
               x_in     = NUM_WIDTH'(1);
               p_in     = base_now;
               e_in     = d_ff;
               state_in = ST_POW_CHK;
            end
         end
         ST_POW_CHK: begin
            if (e_ff == '0) begin
               state_in = ST_CHECK;
            end else if (e_ff[0]) begin
               mm_req.start = 1'b1;
               mm_req.a     = x_ff;
               mm_req.b     = p_ff;
               state_in     = ST_POW_MUL;
            end else begin
               mm_req.start = 1'b1;
               mm_req.a     = p_ff;
               mm_req.b     = p_ff;
               state_in     = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            if (mm_rsp.done) begin
               x_in = mm_rsp.product;
               if (e_ff == NUM_WIDTH'(1)) begin
                  // last exponent bit: the final squaring of p is not needed
                  e_in     = '0;
                  state_in = ST_POW_CHK;
               end else begin
                  mm_req.start = 1'b1;
                  mm_req.a     = p_ff;
                  mm_req.b     = p_ff;
                  state_in     = ST_POW_SQR;
               end
            end
         end
         ST_POW_SQR: begin
            if (mm_rsp.done) begin
               p_in     = mm_rsp.product;
               e_in     = {1'b0, e_ff[NUM_WIDTH-1:1]};
               state_in = ST_POW_CHK;
            end
         end
         ST_CHECK: begin
            if (x_ff == NUM_WIDTH'(1) || x_ff == m1_ff) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_BASE;
            end else begin
               k_in     = CNT_W'(1);
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (k_ff < s_ff) begin
               mm_req.start = 1'b1;
               mm_req.a     = x_ff;
               mm_req.b     = x_ff;
               state_in     = ST_SQ;
            end else begin
               // ran out of squarings without reaching n-1
               result_in = 1'b0;
               state_in  = ST_REPORT;
            end
         end
         ST_SQ: begin
            if (mm_rsp.done) begin
               x_in = mm_rsp.product;
               if (mm_rsp.product == NUM_WIDTH'(1)) begin
                  // nontrivial square root of one: composite
                  result_in = 1'b0;
                  state_in  = ST_REPORT;
               end else if (mm_rsp.product == m1_ff) begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_BASE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = ST_LOOP;
               end
            end
         end
         ST_REPORT: begin
            // wait for a free output slot, then load it
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      m1_ff       <= m1_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      x_ff        <= x_in;
      p_ff        <= p_in;
      s_ff        <= s_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

>>> verif/tb_miller_rabin_prime_test.sv
// Tracks candidates in transfer order and checks each verdict against its own prediction.
class prime_verdict_board;

   bit [7:0]          witness_list [12];
   bit                verdict_q [$];
   mrpt_pkg::num_type cand_q [$];
   int                mismatches;

   function new();
      witness_list = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13,
                       8'd17, 8'd19, 8'd23, 8'd29, 8'd31, 8'd37};
      mismatches   = 0;
   endfunction

   // exact a*b mod n through a double-width product
   function mrpt_pkg::num_type mulmod(mrpt_pkg::num_type a, mrpt_pkg::num_type b,
                                      mrpt_pkg::num_type n);
      logic [2*mrpt_pkg::NUM_WIDTH-1:0] p;
      p = ((2*mrpt_pkg::NUM_WIDTH)'(a) * (2*mrpt_pkg::NUM_WIDTH)'(b))
          % (2*mrpt_pkg::NUM_WIDTH)'(n);
      return p[mrpt_pkg::NUM_WIDTH-1:0];
   endfunction

   function bit predict_prime(mrpt_pkg::num_type n);
      mrpt_pkg::num_type m1, d, x, sq, e;
      int                s;
      bit                passed;
      if (!n[0])
         return n == 2;
      if (n < 3)
         return 1'b0;
      m1 = n - 1;
      d  = m1;
      s  = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < mrpt_pkg::BASES_USED; i++) begin
         if (mrpt_pkg::num_type'(witness_list[i]) >= n)
            break;
         // x = base^d mod n, square and multiply from the low bit up
         x  = 1;
         sq = mrpt_pkg::num_type'(witness_list[i]) % n;
         e  = d;
         while (e != 0) begin
            if (e[0])
               x = mulmod(x, sq, n);
            sq = mulmod(sq, sq, n);
            e  = e >> 1;
         end
         if (x == 1 || x == m1)
            continue;
         passed = 1'b0;
         for (int k = 1; k < s; k++) begin
            x = mulmod(x, x, n);
            if (x == 1)
               return 1'b0;
            if (x == m1) begin
               passed = 1'b1;
               break;
            end
         end
         if (!passed)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task note_candidate(mrpt_pkg::num_type n);
      cand_q.push_back(n);
      verdict_q.push_back(predict_prime(n));
   endtask

   task check_verdict(logic [7:0] word);
      bit                want;
      mrpt_pkg::num_type n;
      if (verdict_q.size() == 0) begin
         report_mismatch($sformatf("verdict 0x%02h with no candidate outstanding", word));
         return;
      end
      want = verdict_q.pop_front();
      n    = cand_q.pop_front();
      if (word[0] !== want)
         report_mismatch($sformatf("candidate %0d is_prime got %b want %b", n, word[0], want));
      if (word[7:1] !== 7'd0)
         report_mismatch($sformatf("candidate %0d pad bits got 0x%02h", n, word[7:1]));
   endtask

   function int pending();
      return verdict_q.size();
   endfunction

   task close_out();
      while (verdict_q.size() != 0) begin
         report_mismatch($sformatf("no verdict for candidate %0d", cand_q.pop_front()));
         void'(verdict_q.pop_front());
      end
   endtask

endclass

module tb_miller_rabin_prime_test;
   import mrpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // bound on a correct run: ~100 transfers, each at worst a full 64-bit prime test,
   // taken several times over
   localparam int CYCLE_LIMIT = 100_000_000;
   localparam int HOLD_CYCLES = 400;   // long result back-pressure stretch
   localparam int TAIL_CYCLES = 60;    // trivial candidates finish well within it

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // [63:0] candidate
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [0] is_prime, [7:1] zero

   prime_verdict_board board;

   int          send_idle_pct;   // chance per cycle that the source sits idle
   int          rsp_stall_pct;   // chance per cycle that the sink drops ready
   bit          hold_req;        // asks the sink process for a long hold-off
   bit          hold_taken;      // sink side: the hold-off has been served
   int          cycle_count = 0;
   logic [63:0] directed_list [23];

   miller_rabin_prime_test u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a hung block ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("miller_rabin_prime_test verification failed");
         $finish;
      end
   end

   // Result sink. Ready is random per cycle at the current stall rate; on
   // request it holds off for HOLD_CYCLES so the block backs up and stalls
   // its input side.
   initial begin
      rsp_tready = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Result monitor: values read at the edge are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_verdict(rsp_tdata);
   end

   // Offer one candidate, with random idle cycles ahead of it, and hold it
   // until the transfer. Valid stays high on return so back-to-back
   // transfers need no second assignment in one step.
   task send_candidate(logic [63:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= n;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      board.note_candidate(num_type'(n));
   endtask

   task wait_drained();
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // Random candidate mix. Large primes are the slowest to test, so most draws are
   // small; full-width values cover every bit and mostly fail at the first
   // base; 2^k +/- 1 gives long runs of squarings.
   function automatic logic [63:0] draw_candidate();
      logic [63:0] v;
      logic [31:0] p, q;
      int          k;
      case ($urandom_range(9))
         0, 1, 2, 3: v = 64'($urandom_range(4095));
         4:          v = {$urandom, $urandom} & ~64'd1;
         5, 6:       v = {$urandom, $urandom};
         7:          v = {32'd0, $urandom};
         8: begin
            // odd product of two odd factors, composite unless one is 1
            p = $urandom_range(65535) | 32'd1;
            q = $urandom_range(65535) | 32'd1;
            v = 64'(p) * 64'(q);
         end
         default: begin
            k = $urandom_range(2, 63);
            v = (64'd1 << k) - 64'd1 + 64'(2 * $urandom_range(1));
         end
      endcase
      return v;
   endfunction

   initial begin
      board         = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 64'd0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req      = 1'b0;

      // zero, one, two, small primes, base equal to the candidate, Carmichael
      // number, strong pseudoprimes that fool the leading bases, extreme
      // 64-bit values, Mersenne and Fermat shapes with long trailing zeros
      directed_list = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd37, 64'd41,
         64'd561, 64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751,
         64'd3825123056546413051, 64'd18446744073709551557,
         64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
         64'h1FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
         64'd4294967291, 64'd4294967297, 64'd65537
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pass, back to back with the sink always ready
      foreach (directed_list[i])
         send_candidate(directed_list[i]);
      req_tvalid <= 1'b0;
      wait_drained();

      // back-pressure: sink holds off while even (fast) candidates keep
      // coming, so the result stays parked and input ready drops
      hold_req = 1'b1;
      repeat (12)
         send_candidate({$urandom, $urandom} & ~64'd1);
      req_tvalid <= 1'b0;
      // source pauses until every outstanding verdict is back
      wait_drained();

      // random phases: no idling, source gaps, sink stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         repeat (16)
            send_candidate(draw_candidate());
         req_tvalid <= 1'b0;
         wait_drained();
      end

      // let any stray extra transfer show up before closing
      repeat (TAIL_CYCLES) @(posedge clock);
      board.close_out();
      if (board.mismatches == 0)
         $display("miller_rabin_prime_test verification clean");
      else
         $display("miller_rabin_prime_test verification failed");
      $finish;
   end

endmodule
